@@ design/hdr_exposure_tone_mapper_defines.svh @@
// Assertion macros for the HDR exposure tone mapper.
// Clock i_clk and reset i_rst_n are taken from the module that uses them.
`ifndef HDR_EXPOSURE_TONE_MAPPER_DEFINES_SVH
`define HDR_EXPOSURE_TONE_MAPPER_DEFINES_SVH

// Property that holds at every edge out of reset.
`define HETM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define HETM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HETM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/hetm_pkg.sv @@
// Shared types, constants and latencies of the HDR exposure tone mapper.
// No dependencies.
package hetm_pkg;

    localparam int HETM_FRAC_BITS = 8;
    localparam int HETM_CH_W      = 16;
    localparam int HETM_OUT_W     = 8;
    localparam int HETM_IDX_W     = 8;
    localparam int HETM_DATA_W    = 16;

    localparam logic [31:0] HETM_LOG2E_Q30 = 32'h5C551D95;
    localparam logic [31:0] HETM_LN2_Q32   = 32'hB17217F8;

    localparam int HETM_TERMS    = 20;
    localparam int HETM_X_W      = 40;
    localparam int HETM_POW_LIM  = 40;
    localparam int HETM_GAMMA_NUM = 5;
    localparam int HETM_GAMMA_DEN = 11;
    localparam int HETM_DIV_W    = 40;
    localparam int HETM_DIV_DIG  = 4;
    localparam int HETM_DIV_LAT  = HETM_DIV_W / HETM_DIV_DIG;

    localparam int HETM_POW_LAT  = 3 * (HETM_TERMS - 1) + 2;
    localparam int HETM_NORM_LAT = 5;
    localparam int HETM_NLOG_LAT = HETM_NORM_LAT + 32 + 1;
    localparam int HETM_CH_LAT   = 2 + HETM_POW_LAT + 1 + HETM_NLOG_LAT + 1
                                   + HETM_DIV_LAT + HETM_POW_LAT + 1;

    typedef enum logic [HETM_IDX_W-1:0] {
        CFG_TONEMAP_ENABLE = 8'd0,
        CFG_EXPOSURE_GAIN  = 8'd1
    } t_cfg_idx;

    typedef struct packed {
        logic                 tonemap_enable;
        logic [HETM_CH_W-1:0] exposure_gain;
    } t_chan_cfg;

    typedef struct packed {
        logic [HETM_OUT_W-1:0] value;
        logic                  clip;
    } t_chan_res;

    typedef struct packed {
        logic [HETM_OUT_W-1:0] red;
        logic [HETM_OUT_W-1:0] green;
        logic [HETM_OUT_W-1:0] blue;
        logic                  clipped;
    } t_pix_out;

endpackage

@@ design/hetm_if.sv @@
// Channel interfaces of the HDR exposure tone mapper: pixel in, pixel out, config write.
// Depends on hetm_pkg.
interface hetm_pix_in_if import hetm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [HETM_CH_W-1:0] red_in;
    logic [HETM_CH_W-1:0] green_in;
    logic [HETM_CH_W-1:0] blue_in;
    modport source (output valid, output red_in, output green_in, output blue_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface hetm_pix_out_if import hetm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [HETM_OUT_W-1:0] red_out;
    logic [HETM_OUT_W-1:0] green_out;
    logic [HETM_OUT_W-1:0] blue_out;
    logic                  clipped;
    modport source (output valid, output red_out, output green_out, output blue_out,
                    output clipped, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input clipped, output ready);
endinterface

interface hetm_cfg_if import hetm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [HETM_IDX_W-1:0]  index;
    logic [HETM_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/hetm_delay.sv @@
// Enable-gated delay line for side-band bits travelling beside the datapath.
// Depends on hetm_pkg.
module hetm_delay import hetm_pkg::*; #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_q [0:D-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int j = 1; j < D; j++) begin
                r_q[j] <= r_q[j-1];
            end
        end
    end

    assign o_q = r_q[D-1];
endmodule

@@ design/hetm_pow2.sv @@
// Pipelined 2^(-x), x in Q32: Taylor series of exp(-f*ln2), one term per three stages.
// Depends on hetm_pkg.
module hetm_pow2 import hetm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [HETM_X_W-1:0] i_x,
    output logic [32:0]         o_g
);
    localparam int NK    = HETM_TERMS;
    localparam int ACC_W = 35;
    localparam int N_W   = HETM_X_W - 32;
    localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(1) << 32;

    logic [31:0]      r_term [1:NK];
    logic [31:0]      r_u    [1:NK];
    logic [ACC_W-1:0] r_acc  [1:NK];
    logic [N_W-1:0]   r_n    [1:NK];

    logic [31:0]      r_pa   [2:NK];
    logic [31:0]      r_ua   [2:NK];
    logic [ACC_W-1:0] r_acca [2:NK];
    logic [N_W-1:0]   r_na   [2:NK];

    logic [31:0]      r_qb   [2:NK];
    logic [31:0]      r_pb   [2:NK];
    logic [31:0]      r_ub   [2:NK];
    logic [ACC_W-1:0] r_accb [2:NK];
    logic [N_W-1:0]   r_nb   [2:NK];

    logic [32:0]      r_g;
    logic [31:0]      n_u;

    // first term is u itself
    assign n_u = 32'((64'(i_x[31:0]) * 64'(HETM_LN2_Q32)) >> 32);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term[1] <= n_u;
            r_u[1]    <= n_u;
            r_acc[1]  <= ACC_ONE - ACC_W'(n_u);
            r_n[1]    <= i_x[HETM_X_W-1:32];
        end
    end

    for (genvar k = 2; k <= NK; k++) begin : g_term
        localparam logic [31:0] RECIP = 32'((64'd1 << 32) / k);
        localparam logic [36:0] KV    = 37'(k);
        logic [31:0] n_p;
        logic [31:0] n_q;
        logic [36:0] n_rem;
        logic [31:0] n_t;

        assign n_p   = 32'((64'(r_term[k-1]) * 64'(r_u[k-1])) >> 32);
        assign n_q   = 32'((64'(r_pa[k]) * 64'(RECIP)) >> 32);
        // estimate is exact or one short
        assign n_rem = 37'(r_pb[k]) - 37'(r_qb[k]) * KV;
        assign n_t   = (n_rem >= KV) ? r_qb[k] + 32'd1 : r_qb[k];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pa[k]   <= n_p;
                r_ua[k]   <= r_u[k-1];
                r_acca[k] <= r_acc[k-1];
                r_na[k]   <= r_n[k-1];

                r_qb[k]   <= n_q;
                r_pb[k]   <= r_pa[k];
                r_ub[k]   <= r_ua[k];
                r_accb[k] <= r_acca[k];
                r_nb[k]   <= r_na[k];

                r_term[k] <= n_t;
                r_u[k]    <= r_ub[k];
                r_n[k]    <= r_nb[k];
                if (k % 2 == 1) begin
                    r_acc[k] <= r_accb[k] - ACC_W'(n_t);
                end else begin
                    r_acc[k] <= r_accb[k] + ACC_W'(n_t);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_n[NK] >= N_W'(HETM_POW_LIM)) begin
                r_g <= '0;
            end else begin
                r_g <= r_acc[NK][32:0] >> r_n[NK];
            end
        end
    end

    assign o_g = r_g;
endmodule

@@ design/hetm_nlog2.sv @@
// Pipelined -log2(y) in Q32 for 0 < y < 2^32: staged normalisation, then
// one squaring per stage. Depends on hetm_pkg.
module hetm_nlog2 import hetm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_y,
    output logic [37:0] o_l
);
    localparam int NS = HETM_NORM_LAT;

    logic [31:0] w_ny_in [0:NS-1];
    logic [4:0]  w_m_in  [0:NS-1];
    logic [31:0] r_ny    [0:NS-1];
    logic [4:0]  r_m     [0:NS-1];

    logic [31:0] w_w_in  [0:31];
    logic [31:0] w_lf_in [0:31];
    logic [4:0]  w_sm_in [0:31];
    logic [31:0] r_w     [0:31];
    logic [31:0] r_lf    [0:31];
    logic [4:0]  r_sm    [0:31];

    logic [37:0] r_l;

    assign w_ny_in[0] = i_y;
    assign w_m_in[0]  = '0;

    for (genvar s = 0; s < NS; s++) begin : g_norm
        localparam int SH = 16 >> s;
        if (s > 0) begin : g_link
            assign w_ny_in[s] = r_ny[s-1];
            assign w_m_in[s]  = r_m[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_ny_in[s][31 -: SH] == '0) begin
                    r_ny[s] <= w_ny_in[s] << SH;
                    r_m[s]  <= w_m_in[s] + 5'(SH);
                end else begin
                    r_ny[s] <= w_ny_in[s];
                    r_m[s]  <= w_m_in[s];
                end
            end
        end
    end

    assign w_w_in[0]  = r_ny[NS-1];
    assign w_lf_in[0] = '0;
    assign w_sm_in[0] = r_m[NS-1];

    for (genvar j = 0; j < 32; j++) begin : g_sq
        localparam int BIT = 31 - j;
        logic [32:0] n_sq;
        if (j > 0) begin : g_link
            assign w_w_in[j]  = r_w[j-1];
            assign w_lf_in[j] = r_lf[j-1];
            assign w_sm_in[j] = r_sm[j-1];
        end
        assign n_sq = 33'((64'(w_w_in[j]) * 64'(w_w_in[j])) >> 31);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sm[j] <= w_sm_in[j];
                if (n_sq[32]) begin
                    r_w[j]  <= n_sq[32:1];
                    r_lf[j] <= w_lf_in[j] | (32'd1 << BIT);
                end else begin
                    r_w[j]  <= n_sq[31:0];
                    r_lf[j] <= w_lf_in[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l <= ((38'(r_sm[31]) + 38'd1) << 32) - 38'(r_lf[31]);
        end
    end

    assign o_l = r_l;
endmodule

@@ design/hetm_chan.sv @@
// One colour channel: exposure curve, -log2, times 5/11, 2^(-x), scale to 8 bits.
// Depends on hetm_pkg, hetm_pow2, hetm_nlog2, hetm_delay.
module hetm_chan import hetm_pkg::*; #(
    parameter int FRAC_BITS = HETM_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  t_chan_cfg            i_cfg,
    input  logic [HETM_CH_W-1:0] i_c,
    output t_chan_res            o_res
);
    localparam int XSH = FRAC_BITS + 6;
    localparam logic [32:0] ONE33 = 33'(1) << 32;
    localparam logic [32:0] BIG   = 33'(32) << (FRAC_BITS + 8);
    localparam logic [16:0] UNITY = 17'(1) << FRAC_BITS;
    localparam int FLAG_LAT = HETM_NLOG_LAT + 1 + HETM_DIV_LAT + HETM_POW_LAT;

    typedef struct packed {
        logic        tone;
        logic        clip;
        logic        big;
        logic [32:0] yoff;
    } t_tone_side;

    typedef struct packed {
        logic clip;
        logic zero;
    } t_out_flags;

    // stage 1
    logic [31:0] r_t;
    logic        r_tone1;
    logic        r_clip1;
    logic [32:0] r_yoff1;
    // stage 2
    logic [HETM_X_W-1:0] r_x2;
    t_tone_side          r_side2;
    t_tone_side          w_side_d;
    logic [32:0]         w_e;
    // stage 3
    logic [32:0] n_y;
    logic [32:0] r_y3;
    t_out_flags  r_fl3;
    t_out_flags  w_fl_d;
    // log and scale
    logic [37:0]           w_l;
    logic                  w_one_d;
    logic [HETM_DIV_W-1:0] r_l5;
    // divider
    logic [3:0]            w_rin [0:HETM_DIV_LAT-1];
    logic [HETM_DIV_W-1:0] w_din [0:HETM_DIV_LAT-1];
    logic [3:0]            r_rem [0:HETM_DIV_LAT-1];
    logic [HETM_DIV_W-1:0] r_div [0:HETM_DIV_LAT-1];
    logic [32:0]           w_g;
    logic [40:0]           n_sc;
    t_chan_res             r_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t     <= 32'(i_c) * 32'(i_cfg.exposure_gain);
            r_tone1 <= i_cfg.tonemap_enable;
            r_clip1 <= !i_cfg.tonemap_enable && (17'(i_c) > UNITY);
            r_yoff1 <= 33'(i_c) << (32 - FRAC_BITS);

            r_x2         <= HETM_X_W'((64'(r_t) * 64'(HETM_LOG2E_Q30)) >> XSH);
            r_side2.tone <= r_tone1;
            r_side2.clip <= r_clip1;
            r_side2.big  <= 33'(r_t) >= BIG;
            r_side2.yoff <= r_yoff1;
        end
    end

    hetm_pow2 u_pow_tone (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_x   (r_x2),
        .o_g   (w_e)
    );

    hetm_delay #(.W($bits(t_tone_side)), .D(HETM_POW_LAT)) u_dly_tone (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (r_side2),
        .o_q   (w_side_d)
    );

    always_comb begin
        if (!w_side_d.tone) begin
            n_y = w_side_d.yoff;
        end else if (w_side_d.big) begin
            n_y = ONE33;
        end else begin
            n_y = ONE33 - w_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y3       <= n_y;
            r_fl3.clip <= w_side_d.clip;
            r_fl3.zero <= (n_y == '0);
        end
    end

    hetm_nlog2 u_nlog (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_y   (r_y3[31:0]),
        .o_l   (w_l)
    );

    hetm_delay #(.W(1), .D(HETM_NLOG_LAT)) u_dly_one (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (r_y3[32]),
        .o_q   (w_one_d)
    );

    // y of exactly 1.0 has zero log
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_one_d) begin
                r_l5 <= '0;
            end else begin
                r_l5 <= HETM_DIV_W'(HETM_GAMMA_NUM) * HETM_DIV_W'(w_l);
            end
        end
    end

    assign w_rin[0] = '0;
    assign w_din[0] = r_l5;

    // long division by the gamma denominator, one hex digit per stage
    for (genvar d = 0; d < HETM_DIV_LAT; d++) begin : g_div
        logic [3:0]            n_rem;
        logic [HETM_DIV_W-1:0] n_div;
        if (d > 0) begin : g_link
            assign w_rin[d] = r_rem[d-1];
            assign w_din[d] = r_div[d-1];
        end
        always_comb begin
            logic [4:0]            v_t;
            logic [3:0]            v_r;
            logic [HETM_DIV_W-1:0] v_d;
            v_r = w_rin[d];
            v_d = w_din[d];
            v_t = '0;
            for (int b = 0; b < HETM_DIV_DIG; b++) begin
                v_t = {v_r, v_d[HETM_DIV_W-1]};
                v_d = {v_d[HETM_DIV_W-2:0], 1'b0};
                if (v_t >= 5'(HETM_GAMMA_DEN)) begin
                    v_t    = v_t - 5'(HETM_GAMMA_DEN);
                    v_d[0] = 1'b1;
                end
                v_r = v_t[3:0];
            end
            n_rem = v_r;
            n_div = v_d;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[d] <= n_rem;
                r_div[d] <= n_div;
            end
        end
    end

    hetm_pow2 u_pow_gamma (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_x   (r_div[HETM_DIV_LAT-1]),
        .o_g   (w_g)
    );

    hetm_delay #(.W($bits(t_out_flags)), .D(FLAG_LAT)) u_dly_flag (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (r_fl3),
        .o_q   (w_fl_d)
    );

    assign n_sc = (41'(w_g) << 8) - 41'(w_g) + (41'(1) << 31);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.clip <= w_fl_d.clip;
            if (w_fl_d.clip) begin
                r_res.value <= '1;
            end else if (w_fl_d.zero) begin
                r_res.value <= '0;
            end else if (n_sc[40:32] > 9'd255) begin
                r_res.value <= '1;
            end else begin
                r_res.value <= n_sc[39:32];
            end
        end
    end

    assign o_res = r_res;
endmodule

@@ design/hdr_exposure_tone_mapper.sv @@
// Top level of the HDR exposure tone mapper: config registers, three channel
// pipelines, valid tracking and a two-entry output buffer.
// Depends on hetm_pkg, hetm_if, hetm_chan and the assertion macro header.
//
//  port    | dir | carries                                    | accepted when
//  --------+-----+--------------------------------------------+----------------------
//  i_pix   | in  | red_in, green_in, blue_in (Q8.8 linear)    | valid && ready
//  o_pix   | out | red_out, green_out, blue_out, clipped      | valid && ready
//  i_cfg   | in  | index, data (register write)               | valid && ready
//
// One item per cycle while the output buffer does not stall the pipeline; the depth from
// acceptance to the output buffer is set by the two 20-term series pipelines and the
// 32-step squaring chain of the log unit.
// Reset sets the config registers to defaults and clears the valid bits and buffer count; no clearing pass.
// The whole pipeline freezes only when its last stage holds an item and the
// output buffer is full; input ready comes from registers alone.
`include "hdr_exposure_tone_mapper_defines.svh"

module hdr_exposure_tone_mapper import hetm_pkg::*; #(
    parameter int CHANNEL_FRAC_BITS = HETM_FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hetm_pix_in_if.sink   i_pix,
    hetm_pix_out_if.source o_pix,
    hetm_cfg_if.sink      i_cfg
);
    localparam int LAT = HETM_CH_LAT;

    logic                 r_tonemap_enable;
    logic [HETM_CH_W-1:0] r_exposure_gain;
    t_chan_cfg            w_cfg;

    logic       r_v [0:LAT-1];
    logic       w_adv;
    logic       w_push;
    logic       w_pop;
    logic [1:0] r_cnt;
    t_pix_out   r_head;
    t_pix_out   r_skid;
    t_pix_out   w_new;
    t_chan_res  w_red;
    t_chan_res  w_green;
    t_chan_res  w_blue;

    // config: always ready, unknown indices dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tonemap_enable <= 1'b1;
            r_exposure_gain  <= HETM_CH_W'(256);
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_TONEMAP_ENABLE: begin
                    r_tonemap_enable <= i_cfg.data[0];
                end
                CFG_EXPOSURE_GAIN: begin
                    r_exposure_gain <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.tonemap_enable = r_tonemap_enable;
    assign w_cfg.exposure_gain  = r_exposure_gain;

    // advance unless a finished item has nowhere to go
    assign w_adv       = !r_v[LAT-1] || (r_cnt != 2'd2);
    assign i_pix.ready = w_adv;
    assign w_push      = w_adv && r_v[LAT-1];
    assign w_pop       = o_pix.valid && o_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LAT; j++) begin
                r_v[j] <= 1'b0;
            end
        end else if (w_adv) begin
            r_v[0] <= i_pix.valid;
            for (int j = 1; j < LAT; j++) begin
                r_v[j] <= r_v[j-1];
            end
        end
    end

    hetm_chan #(.FRAC_BITS(CHANNEL_FRAC_BITS)) u_chan_red (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_cfg (w_cfg),
        .i_c   (i_pix.red_in),
        .o_res (w_red)
    );

    hetm_chan #(.FRAC_BITS(CHANNEL_FRAC_BITS)) u_chan_green (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_cfg (w_cfg),
        .i_c   (i_pix.green_in),
        .o_res (w_green)
    );

    hetm_chan #(.FRAC_BITS(CHANNEL_FRAC_BITS)) u_chan_blue (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_cfg (w_cfg),
        .i_c   (i_pix.blue_in),
        .o_res (w_blue)
    );

    assign w_new.red     = w_red.value;
    assign w_new.green   = w_green.value;
    assign w_new.blue    = w_blue.value;
    assign w_new.clipped = w_red.clip || w_green.clip || w_blue.clip;

    // output buffer: head drives the port, skid catches one more item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({w_push, w_pop})
                2'b10: begin
                    r_cnt <= r_cnt + 2'd1;
                end
                2'b01: begin
                    r_cnt <= r_cnt - 2'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && !w_pop) begin
            if (r_cnt == 2'd0) begin
                r_head <= w_new;
            end else begin
                r_skid <= w_new;
            end
        end else if (w_push && w_pop) begin
            if (r_cnt == 2'd1) begin
                r_head <= w_new;
            end else begin
                r_head <= r_skid;
                r_skid <= w_new;
            end
        end else if (w_pop && r_cnt == 2'd2) begin
            r_head <= r_skid;
        end
    end

    assign o_pix.valid     = (r_cnt != 2'd0);
    assign o_pix.red_out   = r_head.red;
    assign o_pix.green_out = r_head.green;
    assign o_pix.blue_out  = r_head.blue;
    assign o_pix.clipped   = r_head.clipped;

    `HETM_ASSERT_ALWAYS(a_buf_bound, r_cnt != 2'd3, "output buffer count out of range")
    `HETM_ASSERT_IMPL(a_full_stall, r_v[LAT-1] && r_cnt == 2'd2, !i_pix.ready,
        "pipeline advanced into a full output buffer")
    `HETM_ASSERT_NEXT(a_drain, r_cnt == 2'd2 && w_pop, r_cnt == 2'd1 && o_pix.valid,
        "output buffer lost or repeated an item while draining")
    `HETM_ASSERT_IMPL(a_clip_sat, o_pix.valid && o_pix.clipped,
        o_pix.red_out == 8'hFF || o_pix.green_out == 8'hFF || o_pix.blue_out == 8'hFF,
        "clipped item without a saturated channel")
endmodule

@@ sim/hdr_exposure_tone_mapper_tb.sv @@
// Self-checking testbench for the HDR exposure tone mapper: pixel stream in, display pixels out.
// Depends on hetm_pkg, the hetm_if interfaces and the hdr_exposure_tone_mapper RTL.
module hdr_exposure_tone_mapper_tb;
    import hetm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
    localparam int          DRAIN_CYCLES = HETM_CH_LAT + 50;

    typedef struct packed {
        logic [HETM_CH_W-1:0] red;
        logic [HETM_CH_W-1:0] green;
        logic [HETM_CH_W-1:0] blue;
    } t_pix_in;

    // Pixel predictor: mirrors the fixed-point exposure curve and gamma 5/11.
    class tone_scoreboard;
        logic                 tonemap_on;
        logic [HETM_CH_W-1:0] gain;
        t_pix_out             pending[$];
        int                   mismatches;
        int                   matched;

        function new();
            tonemap_on = 1'b1;
            gain       = 16'd256;
            mismatches = 0;
            matched    = 0;
        endfunction

        // 2^(-f) for a Q32 fraction, by alternating Taylor series of exp(-f*ln2).
        function automatic logic [63:0] exp2_frac(logic [63:0] f);
            logic [63:0] u, term, pos, neg;
            u    = ((f & 64'hFFFF_FFFF) * 64'(HETM_LN2_Q32)) >> 32;
            term = ONE_Q32;
            pos  = ONE_Q32;
            neg  = '0;
            for (int k = 1; k <= HETM_TERMS; k++) begin
                term = ((term * u) >> 32) / 64'(k);
                if (k & 1) neg += term;
                else       pos += term;
            end
            return pos - neg;
        endfunction

        function automatic logic [63:0] exp2_neg(logic [63:0] x);
            logic [63:0] n;
            n = x >> 32;
            if (n >= 64'(HETM_POW_LIM)) return '0;
            return exp2_frac(x & 64'hFFFF_FFFF) >> n;
        endfunction

        // -log2(y) in Q32 via normalisation and bitwise squaring.
        function automatic logic [63:0] neglog2(logic [63:0] y);
            logic [63:0] m, w, lf;
            m  = '0;
            lf = '0;
            if (y >= ONE_Q32) return '0;
            while (y < 64'h8000_0000) begin
                y = y << 1;
                m++;
            end
            w = y;
            for (int i = 31; i >= 0; i--) begin
                w = (w * w) >> 31;
                if (w >= ONE_Q32) begin
                    w = w >> 1;
                    lf |= 64'd1 << i;
                end
            end
            return ((m + 64'd1) << 32) - lf;
        endfunction

        function automatic t_chan_res display_value(logic [HETM_CH_W-1:0] c);
            logic [63:0] t, y, g, o;
            t_chan_res   r;
            r.clip = 1'b0;
            if (tonemap_on) begin
                t = 64'(c) * 64'(gain);
                if (t >= (64'd32 << (HETM_FRAC_BITS + 8))) y = ONE_Q32;
                else y = ONE_Q32 - exp2_neg((t * 64'(HETM_LOG2E_Q30)) >> (HETM_FRAC_BITS + 6));
            end else begin
                if (c > (16'd1 << HETM_FRAC_BITS)) begin
                    r.value = 8'd255;
                    r.clip  = 1'b1;
                    return r;
                end
                y = 64'(c) << (32 - HETM_FRAC_BITS);
            end
            if (y == 0) begin
                r.value = '0;
                return r;
            end
            g = exp2_neg((neglog2(y) * 64'(HETM_GAMMA_NUM)) / 64'(HETM_GAMMA_DEN));
            o = (64'd255 * g + 64'h8000_0000) >> 32;
            r.value = (o > 64'd255) ? 8'd255 : o[7:0];
            return r;
        endfunction

        function void note_pixel(t_pix_in p);
            t_chan_res r, g, b;
            t_pix_out  e;
            r = display_value(p.red);
            g = display_value(p.green);
            b = display_value(p.blue);
            e.red     = r.value;
            e.green   = g.value;
            e.blue    = b.value;
            e.clipped = r.clip | g.clip | b.clip;
            pending.push_back(e);
        endfunction

        function void check_pixel(t_pix_out got);
            t_pix_out e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected pixel %p", got);
                return;
            end
            e = pending.pop_front();
            if (e !== got) begin
                mismatches++;
                if (mismatches <= 10) $display("pixel mismatch: expected %p got %p", e, got);
            end else begin
                matched++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    hetm_pix_in_if  pix_in ();
    hetm_pix_out_if pix_out ();
    hetm_cfg_if     cfg ();

    hdr_exposure_tone_mapper u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .i_cfg   (cfg)
    );

    tone_scoreboard sb = new();
    bit             no_idle;   // long stretch with neither side idling
    int             pixels_sent;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Sink side: stall about 7 percent of the time unless no_idle is set, check every accepted pixel.
    initial begin
        t_pix_out got;
        pix_out.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pix_out.valid && pix_out.ready) begin
                got.red     = pix_out.red_out;
                got.green   = pix_out.green_out;
                got.blue    = pix_out.blue_out;
                got.clipped = pix_out.clipped;
                sb.check_pixel(got);
            end
            @(negedge i_clk);
            pix_out.ready <= no_idle || ($urandom_range(99) >= 7);
        end
    end

    // Present one pixel, holding valid until accepted; note it at acceptance.
    // Valid stays high after acceptance; the next call replaces the pixel or drops valid, and drain() drops it.
    task automatic send_pixel(t_pix_in p);
        while (!no_idle && $urandom_range(99) < 7) begin
            pix_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.red_in   <= p.red;
        pix_in.green_in <= p.green;
        pix_in.blue_in  <= p.blue;
        do @(posedge i_clk); while (!pix_in.ready);
        sb.note_pixel(p);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // Write a register while the pipe is idle; update the predictor at acceptance.
    task automatic write_reg(t_cfg_idx idx, logic [HETM_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge i_clk); while (!cfg.ready);
        if (idx == CFG_TONEMAP_ENABLE) sb.tonemap_on = value[0];
        else if (idx == CFG_EXPOSURE_GAIN) sb.gain = value;
        @(negedge i_clk);
        cfg.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Hold until every expected pixel is back; then let the pipe settle.
    task automatic drain();
        pix_in.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Random radiance: mostly around the interesting region near 1.0, some full-range.
    function automatic logic [HETM_CH_W-1:0] rand_chan();
        case ($urandom_range(3))
            0:       return HETM_CH_W'($urandom_range(16'hFFFF));
            1:       return HETM_CH_W'($urandom_range(512));
            2:       return HETM_CH_W'($urandom_range(16'h0FFF));
            default: return HETM_CH_W'($urandom_range(64));
        endcase
    endfunction

    function automatic t_pix_in pix(int r, int g, int b);
        t_pix_in p;
        p.red   = HETM_CH_W'(r);
        p.green = HETM_CH_W'(g);
        p.blue  = HETM_CH_W'(b);
        return p;
    endfunction

    initial begin
        logic [HETM_DATA_W-1:0] gains[6];
        t_pix_in                p;
        gains = '{16'd256, 16'd0, 16'hFFFF, 16'd1, 16'd64, 16'd1024};
        i_rst_n      = 1'b0;
        no_idle      = 1'b0;
        pixels_sent  = 0;
        pix_in.valid = 1'b0;
        pix_in.red_in = '0; pix_in.green_in = '0; pix_in.blue_in = '0;
        cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset settings, extremes, saturation of the exposure product.
        send_pixel(pix(0, 16'hFFFF, 256));
        send_pixel(pix(1, 16'h2000, 16'h1FFF));
        send_pixel(pix(16'hAAAA, 16'h5555, 128));
        drain();
        write_reg(CFG_EXPOSURE_GAIN, 16'd0);          // zero exposure gives black
        send_pixel(pix(16'hFFFF, 256, 1));
        drain();
        write_reg(CFG_EXPOSURE_GAIN, 16'hFFFF);
        send_pixel(pix(1, 2, 16'hFFFF));
        drain();
        // Gamma only: exactly 1.0 does not clip, just above does.
        write_reg(CFG_TONEMAP_ENABLE, 16'd0);
        send_pixel(pix(256, 255, 0));
        send_pixel(pix(257, 0, 0));
        send_pixel(pix(0, 0, 16'hFFFF));
        send_pixel(pix(1, 128, 16'h8000));
        send_pixel(pix(16'h5555, 16'hAAAA, 64));
        drain();
        write_reg(CFG_TONEMAP_ENABLE, 16'd1);
        write_reg(CFG_EXPOSURE_GAIN, 16'd256);

        // Random phases across settings; a stretch without idling in the middle.
        for (int ph = 0; ph < 12; ph++) begin
            no_idle = (ph == 5 || ph == 6);
            write_reg(CFG_TONEMAP_ENABLE, (ph % 3 == 2) ? 16'd0 : 16'd1);
            write_reg(CFG_EXPOSURE_GAIN,
                      (ph < 6) ? gains[ph] : 16'($urandom_range(16'hFFFF)));
            for (int i = 0; i < 62; i++) begin
                p.red   = rand_chan();
                p.green = rand_chan();
                p.blue  = rand_chan();
                send_pixel(p);
            end
            drain();
        end
        no_idle = 1'b0;

        $display("covered %0d pixels over both tone modes and exposure gains 0 to 0xFFFF",
                 pixels_sent);
        $display("matched %0d pixels, %0d mismatches", sb.matched, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far above the slowest correct run.
    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
